/* hdl/btgl_pkg.sv */
// Shared types, codes and helpers of the bitmap text glyph layout block.
package btgl_pkg;

  // Glyph table geometry
  localparam int GLYPH_SLOTS_DEF = 43;
  localparam int SLOT_W          = 6;

  // Slot bases for the character groups
  localparam logic [SLOT_W-1:0] SLOT_DIGIT0 = 6'd26;
  localparam logic [SLOT_W-1:0] SLOT_STAR   = 6'd36;
  localparam logic [SLOT_W-1:0] SLOT_DOT    = 6'd37;
  localparam logic [SLOT_W-1:0] SLOT_COLON  = 6'd38;
  localparam logic [SLOT_W-1:0] SLOT_MINUS  = 6'd39;
  localparam logic [SLOT_W-1:0] SLOT_EQUAL  = 6'd40;
  localparam logic [SLOT_W-1:0] SLOT_BANG   = 6'd41;
  localparam logic [SLOT_W-1:0] SLOT_QUEST  = 6'd42;

  // Request kinds
  localparam logic [1:0] KIND_LOAD  = 2'd0;
  localparam logic [1:0] KIND_START = 2'd1;
  localparam logic [1:0] KIND_CHAR  = 2'd2;

  // Configuration register indexes
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_SPACE_WIDTH = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LINE_HEIGHT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_GLYPH_GAP   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_COLOR_RED   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_COLOR_GREEN = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_COLOR_BLUE  = 3'd5;

  // Character codes with special handling
  localparam logic [7:0] CH_TAB     = 8'h09;
  localparam logic [7:0] CH_NEWLINE = 8'h0a;
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_STAR    = 8'h2a;
  localparam logic [7:0] CH_MINUS   = 8'h2d;
  localparam logic [7:0] CH_DOT     = 8'h2e;
  localparam logic [7:0] CH_ZERO    = 8'h30;
  localparam logic [7:0] CH_NINE    = 8'h39;
  localparam logic [7:0] CH_COLON   = 8'h3a;
  localparam logic [7:0] CH_EQUAL   = 8'h3d;
  localparam logic [7:0] CH_BANG    = 8'h21;
  localparam logic [7:0] CH_QUEST   = 8'h3f;
  localparam logic [7:0] CH_UPPER_A = 8'h41;
  localparam logic [7:0] CH_UPPER_Z = 8'h5a;
  localparam logic [7:0] CH_LOWER_A = 8'h61;
  localparam logic [7:0] CH_LOWER_Z = 8'h7a;

  // Texture u marking an absent glyph
  localparam logic [7:0] ABSENT_U = 8'hff;

  // Reset values of the configuration registers
  localparam logic [7:0] RST_SPACE_WIDTH = 8'd8;
  localparam logic [7:0] RST_LINE_HEIGHT = 8'd11;
  localparam logic [7:0] RST_GLYPH_GAP   = 8'd1;
  localparam logic [7:0] RST_COLOR       = 8'd128;

  typedef struct packed {
    logic [1:0]         kind;
    logic [7:0]         char_code;
    logic [5:0]         entry_index;
    logic [7:0]         entry_u;
    logic [7:0]         entry_v;
    logic [7:0]         entry_width;
    logic [7:0]         entry_height;
    logic signed [15:0] start_x;
    logic signed [15:0] start_y;
  } in_req_t;

  typedef struct packed {
    logic               draw;
    logic signed [15:0] sprite_x;
    logic signed [15:0] sprite_y;
    logic [7:0]         tex_u;
    logic [7:0]         tex_v;
    logic [7:0]         sprite_width;
    logic [7:0]         sprite_height;
    logic [7:0]         sprite_red;
    logic [7:0]         sprite_green;
    logic [7:0]         sprite_blue;
    logic [15:0]        widest_extent;
  } out_rsp_t;

  typedef struct packed {
    logic [7:0] u;
    logic [7:0] v;
    logic [7:0] w;
    logic [7:0] h;
  } glyph_t;

  typedef struct packed {
    logic              hit;
    logic [SLOT_W-1:0] slot;
  } slot_map_t;

  // Map a character code onto its glyph slot
  function automatic slot_map_t slot_of(input logic [7:0] c);
    slot_map_t m;
    m.hit  = 1'b1;
    m.slot = '0;
    if (c >= CH_LOWER_A && c <= CH_LOWER_Z) begin
      m.slot = SLOT_W'(c - CH_LOWER_A);
    end else if (c >= CH_UPPER_A && c <= CH_UPPER_Z) begin
      m.slot = SLOT_W'(c - CH_UPPER_A);
    end else if (c >= CH_ZERO && c <= CH_NINE) begin
      m.slot = SLOT_DIGIT0 + SLOT_W'(c - CH_ZERO);
    end else begin
      case (c)
        CH_STAR:  m.slot = SLOT_STAR;
        CH_DOT:   m.slot = SLOT_DOT;
        CH_COLON: m.slot = SLOT_COLON;
        CH_MINUS: m.slot = SLOT_MINUS;
        CH_EQUAL: m.slot = SLOT_EQUAL;
        CH_BANG:  m.slot = SLOT_BANG;
        CH_QUEST: m.slot = SLOT_QUEST;
        default:  m.hit  = 1'b0;
      endcase
    end
    return m;
  endfunction

endpackage

/* hdl/btgl_glyph_ram.sv */
// Glyph table memory: one write port, one read port with registered data.
module btgl_glyph_ram #(
  parameter int GLYPH_SLOTS = btgl_pkg::GLYPH_SLOTS_DEF,
  parameter int AW          = $clog2(GLYPH_SLOTS)
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [AW-1:0]     wr_addr,
  input  btgl_pkg::glyph_t  wr_data,
  input  logic              rd_en,
  input  logic [AW-1:0]     rd_addr,
  output btgl_pkg::glyph_t  rd_data
);

  btgl_pkg::glyph_t mem [GLYPH_SLOTS];
  btgl_pkg::glyph_t rd_data_r;

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read port, data registered
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

/* hdl/bitmap_text_glyph_layout_top.sv */
// Top level of the bitmap text glyph layout block.
// Takes one request per cycle unless in_stall is high: glyph table loads, string starts
// and characters. Each character gives one sprite result via the table read register,
// then the cursor update into the output register; loads, starts and kind 3 give none.
// The sustained rate is one request per clock unless the output stalls, set by the cursor
// add and the one read port of the 43-entry glyph table. Configuration writes are always
// ready and take effect on the next cycle; write them only while the block is idle.
module bitmap_text_glyph_layout_top #(
  parameter int GLYPH_SLOTS = btgl_pkg::GLYPH_SLOTS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  btgl_pkg::in_req_t                   in_data,
  output logic                                out_valid,
  input  logic                                out_stall,
  output btgl_pkg::out_rsp_t                  out_data,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [btgl_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [7:0]                          cfg_data
);

  localparam int AW = $clog2(GLYPH_SLOTS);

  // Configuration registers
  logic [7:0] space_width_r, line_height_r, glyph_gap_r;
  logic [7:0] color_red_r, color_green_r, color_blue_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      space_width_r <= btgl_pkg::RST_SPACE_WIDTH;
      line_height_r <= btgl_pkg::RST_LINE_HEIGHT;
      glyph_gap_r   <= btgl_pkg::RST_GLYPH_GAP;
      color_red_r   <= btgl_pkg::RST_COLOR;
      color_green_r <= btgl_pkg::RST_COLOR;
      color_blue_r  <= btgl_pkg::RST_COLOR;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        btgl_pkg::CFG_SPACE_WIDTH: space_width_r <= cfg_data;
        btgl_pkg::CFG_LINE_HEIGHT: line_height_r <= cfg_data;
        btgl_pkg::CFG_GLYPH_GAP:   glyph_gap_r   <= cfg_data;
        btgl_pkg::CFG_COLOR_RED:   color_red_r   <= cfg_data;
        btgl_pkg::CFG_COLOR_GREEN: color_green_r <= cfg_data;
        btgl_pkg::CFG_COLOR_BLUE:  color_blue_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  // Handshake and stage control
  logic s1_v_r;
  logic [1:0] s1_kind_r;
  logic [7:0] s1_code_r;
  logic s1_hit_r;
  logic [15:0] s1_start_x_r, s1_start_y_r;
  logic out_v_r;
  btgl_pkg::out_rsp_t out_r, out_nxt;
  logic s1_go, in_acc, s1_is_char;

  assign s1_is_char = (s1_kind_r == btgl_pkg::KIND_CHAR);
  assign s1_go      = s1_v_r && (!s1_is_char || !out_v_r || !out_stall);
  assign in_stall   = s1_v_r && !s1_go;
  assign in_acc     = in_valid && !in_stall;

  // Slot lookup and table write on the incoming request
  btgl_pkg::slot_map_t in_map;
  logic wr_en;
  btgl_pkg::glyph_t wr_data, glyph;

  assign in_map  = btgl_pkg::slot_of(in_data.char_code);
  assign wr_en   = in_acc && (in_data.kind == btgl_pkg::KIND_LOAD) &&
                   (7'(in_data.entry_index) < 7'(GLYPH_SLOTS));
  assign wr_data = '{u: in_data.entry_u, v: in_data.entry_v,
                     w: in_data.entry_width, h: in_data.entry_height};

  btgl_glyph_ram #(
    .GLYPH_SLOTS (GLYPH_SLOTS),
    .AW          (AW)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (in_data.entry_index[AW-1:0]),
    .wr_data (wr_data),
    .rd_en   (in_acc),
    .rd_addr (in_map.hit ? in_map.slot[AW-1:0] : '0),
    .rd_data (glyph)
  );

  // Stage 1 registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (in_acc) begin
      s1_v_r <= 1'b1;
    end else if (s1_go) begin
      s1_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_kind_r    <= in_data.kind;
      s1_code_r    <= in_data.char_code;
      s1_hit_r     <= in_map.hit;
      s1_start_x_r <= in_data.start_x;
      s1_start_y_r <= in_data.start_y;
    end
  end

  // Cursor state
  logic [15:0] cursor_x_r, cursor_y_r, origin_x_r, line_off_r, max_ext_r;
  logic [15:0] cursor_x_nxt, cursor_y_nxt, origin_x_nxt, line_off_nxt, max_ext_nxt;
  logic [15:0] blank, step, adv;
  logic drawn;

  // Cursor update and result assembly
  always_comb begin
    blank        = 16'({1'b0, space_width_r} + {1'b0, glyph_gap_r});
    drawn        = s1_hit_r && (glyph.u != btgl_pkg::ABSENT_U);
    step         = drawn ? 16'({1'b0, glyph.w} + {1'b0, glyph_gap_r}) : blank;
    adv          = 16'd0;
    cursor_x_nxt = cursor_x_r;
    cursor_y_nxt = cursor_y_r;
    origin_x_nxt = origin_x_r;
    line_off_nxt = line_off_r;
    max_ext_nxt  = max_ext_r;
    out_nxt      = '0;
    out_nxt.sprite_x = cursor_x_r;
    out_nxt.sprite_y = cursor_y_r;

    case (s1_kind_r)
      btgl_pkg::KIND_START: begin
        origin_x_nxt = s1_start_x_r;
        cursor_x_nxt = s1_start_x_r;
        cursor_y_nxt = s1_start_y_r;
        line_off_nxt = '0;
        max_ext_nxt  = '0;
      end
      btgl_pkg::KIND_CHAR: begin
        if (s1_code_r == btgl_pkg::CH_NEWLINE) begin
          cursor_y_nxt = cursor_y_r + 16'({1'b0, line_height_r} + {1'b0, glyph_gap_r});
          cursor_x_nxt = origin_x_r;
          line_off_nxt = '0;
        end else begin
          if (s1_code_r == btgl_pkg::CH_SPACE) begin
            adv = blank;
          end else if (s1_code_r == btgl_pkg::CH_TAB) begin
            adv = {blank[13:0], 2'b00};
          end else begin
            adv = step;
          end
          cursor_x_nxt = cursor_x_r + adv;
          line_off_nxt = line_off_r + adv;
          // Widest line tracks only after printable or unknown characters
          if (s1_code_r != btgl_pkg::CH_SPACE && s1_code_r != btgl_pkg::CH_TAB &&
              line_off_nxt > max_ext_r) begin
            max_ext_nxt = line_off_nxt;
          end
          if (s1_code_r != btgl_pkg::CH_SPACE && s1_code_r != btgl_pkg::CH_TAB &&
              drawn) begin
            out_nxt.draw          = 1'b1;
            out_nxt.tex_u         = glyph.u;
            out_nxt.tex_v         = glyph.v;
            out_nxt.sprite_width  = glyph.w;
            out_nxt.sprite_height = glyph.h;
            out_nxt.sprite_red    = color_red_r;
            out_nxt.sprite_green  = color_green_r;
            out_nxt.sprite_blue   = color_blue_r;
          end
        end
        out_nxt.widest_extent = max_ext_nxt;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cursor_x_r <= '0;
      cursor_y_r <= '0;
      origin_x_r <= '0;
      line_off_r <= '0;
      max_ext_r  <= '0;
    end else if (s1_go) begin
      cursor_x_r <= cursor_x_nxt;
      cursor_y_r <= cursor_y_nxt;
      origin_x_r <= origin_x_nxt;
      line_off_r <= line_off_nxt;
      max_ext_r  <= max_ext_nxt;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (s1_go && s1_is_char) begin
      out_v_r <= 1'b1;
    end else if (!out_stall) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go && s1_is_char) begin
      out_r <= out_nxt;
    end
  end

  assign out_valid = out_v_r;
  assign out_data  = out_r;

endmodule
